// ===== design/mdt_pkg.sv =====
// Package for the MPPT duty tracker: widths, mode and register codes,
// the input item and configuration structs. No dependencies.
`default_nettype none

package mdt_pkg;

   localparam int DUTY_W     = 16;
   localparam int VOLT_W     = 16;
   localparam int CURR_W     = 16;
   localparam int POWER_W    = 32;
   localparam int STEP_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [STEP_W-1:0] DUTY_STEP_RESET = 8'd1;
   localparam logic [DUTY_W-1:0] DUTY_MAX_RESET  = 16'hFFFF;

   typedef enum logic [1:0] {
      MODE_STOP     = 2'd0,
      MODE_PNO      = 2'd1,
      MODE_INC_COND = 2'd2,
      MODE_HOLD     = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE      = 2'd0,
      CSR_DUTY_STEP = 2'd1,
      CSR_DUTY_MAX  = 2'd2
   } csr_idx_type;

   typedef struct packed {
      mode_type            mode;
      logic [STEP_W-1:0]   duty_step;
      logic [DUTY_W-1:0]   duty_max;
   } cfg_type;

   typedef struct packed {
      logic                action;
      logic [VOLT_W-1:0]   voltage;
      logic [CURR_W-1:0]   current;
      logic [POWER_W-1:0]  power;
      logic [DUTY_W-1:0]   duty_value;
   } req_item_type;

endpackage

`default_nettype wire

// ===== design/mdt_ifs.sv =====
// Channel interfaces of the MPPT duty tracker: sample/load request,
// duty response and register write. Depends on mdt_pkg.
`default_nettype none

interface mdt_req_if import mdt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                action;
   logic [VOLT_W-1:0]   voltage;
   logic [CURR_W-1:0]   current;
   logic [POWER_W-1:0]  power;
   logic [DUTY_W-1:0]   duty_value;

   modport source (output valid, action, voltage, current, power, duty_value, input ready);
   modport sink   (input valid, action, voltage, current, power, duty_value, output ready);
endinterface

interface mdt_rsp_if import mdt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [DUTY_W-1:0]   duty;

   modport source (output valid, duty, input ready);
   modport sink   (input valid, duty, output ready);
endinterface

interface mdt_csr_if import mdt_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/mdt_csr.sv =====
// Configuration registers of the MPPT duty tracker: mode, duty step and
// duty limit. Depends on mdt_pkg and mdt_csr_if.
`default_nettype none

module mdt_csr import mdt_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mdt_csr_if.sink   csr_chan,
   output cfg_type   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_idx_type'(csr_chan.index))
            CSR_MODE:      cfg_in.mode      = mode_type'(csr_chan.data[1:0]);
            CSR_DUTY_STEP: cfg_in.duty_step = csr_chan.data[STEP_W-1:0];
            CSR_DUTY_MAX:  cfg_in.duty_max  = csr_chan.data[DUTY_W-1:0];
            default: ;  // drop writes to unknown indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode      <= MODE_STOP;
         cfg_ff.duty_step <= DUTY_STEP_RESET;
         cfg_ff.duty_max  <= DUTY_MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== design/mdt_track.sv =====
// Tracking state and step logic of the MPPT duty tracker: previous
// samples, duty register and the per-mode duty update. Depends on mdt_pkg.
`default_nettype none

module mdt_track import mdt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  req_item_type       item,
   input  cfg_type            cfg,
   output logic [DUTY_W-1:0]  duty_next
);

   logic [POWER_W-1:0]  last_power_ff, last_power_in;
   logic [VOLT_W-1:0]   last_voltage_ff, last_voltage_in;
   logic [CURR_W-1:0]   last_current_ff, last_current_in;
   logic [DUTY_W-1:0]   duty_ff, duty_in;

   logic                  v_up;
   logic signed [VOLT_W:0] dv_s, v_s;
   logic signed [CURR_W:0] di_s, i_s;
   logic signed [33:0]    prod_a, prod_b;
   logic signed [34:0]    num;
   logic                  ic_up, ic_down;

   logic [DUTY_W:0]       sum_up;
   logic [DUTY_W-1:0]     up_val, dn_raw, dn_val, load_val, step_ext;

   assign step_ext = {{(DUTY_W-STEP_W){1'b0}}, cfg.duty_step};

   // saturated step up and step down
   assign sum_up  = {1'b0, duty_ff} + {1'b0, step_ext};
   assign up_val  = (sum_up > {1'b0, cfg.duty_max}) ? cfg.duty_max : sum_up[DUTY_W-1:0];
   assign dn_raw  = (duty_ff > step_ext) ? (duty_ff - step_ext) : '0;
   assign dn_val  = (dn_raw > cfg.duty_max) ? cfg.duty_max : dn_raw;
   assign load_val = (item.duty_value > cfg.duty_max) ? cfg.duty_max : item.duty_value;

   assign v_up = item.voltage > last_voltage_ff;

   // division-free incremental conductance: sign(dI*V + I*dV) * sign(dV)
   assign v_s    = signed'({1'b0, item.voltage});
   assign i_s    = signed'({1'b0, item.current});
   assign dv_s   = v_s - signed'({1'b0, last_voltage_ff});
   assign di_s   = i_s - signed'({1'b0, last_current_ff});
   assign prod_a = di_s * v_s;
   assign prod_b = i_s * dv_s;
   assign num    = {prod_a[33], prod_a} + {prod_b[33], prod_b};

   assign ic_up   = (num != '0) && (dv_s != '0) && (num[34] == dv_s[VOLT_W]);
   assign ic_down = (num != '0) && (dv_s != '0) && (num[34] != dv_s[VOLT_W]);

   always_comb begin
      last_power_in   = last_power_ff;
      last_voltage_in = last_voltage_ff;
      last_current_in = last_current_ff;
      duty_in         = duty_ff;
      if (item.action) begin
         duty_in = load_val;
      end else begin
         case (cfg.mode)
            MODE_STOP: begin
               duty_in = '0;
            end
            MODE_PNO: begin
               if (item.power > last_power_ff) begin
                  duty_in = v_up ? up_val : dn_val;
               end else if (item.power < last_power_ff) begin
                  duty_in = v_up ? dn_val : up_val;
               end
               last_power_in   = item.power;
               last_voltage_in = item.voltage;
               last_current_in = item.current;
            end
            MODE_INC_COND: begin
               if (ic_up) begin
                  duty_in = up_val;
               end else if (ic_down) begin
                  duty_in = dn_val;
               end
               last_voltage_in = item.voltage;
               last_current_in = item.current;
            end
            default: ;  // hold: keep duty and samples
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_power_ff   <= '0;
         last_voltage_ff <= '0;
         last_current_ff <= '0;
         duty_ff         <= '0;
      end else if (fire) begin
         last_power_ff   <= last_power_in;
         last_voltage_ff <= last_voltage_in;
         last_current_ff <= last_current_in;
         duty_ff         <= duty_in;
      end
   end

   assign duty_next = duty_in;

endmodule

`default_nettype wire

// ===== design/mppt_duty_tracker_core.sv =====
// MPPT duty tracker top level: input register, tracking step, result register.
// A request is taken into the input register, stepped, and its duty captured in the
// result register, from which the response is offered; a stalled response holds both.
// Throughput: one item per cycle while the response is not stalled; the duty and sample
// registers update when an item steps, so each item sees the state left by the one before.
// Reset (synchronous, active high): pipeline empty, samples and duty 0,
// mode stopped, duty_step 1, duty_max 65535.
`default_nettype none

module mppt_duty_tracker_core import mdt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   mdt_req_if.sink      req_chan,
   mdt_rsp_if.source    rsp_chan,
   mdt_csr_if.sink      csr_chan
);

   cfg_type             cfg;
   req_item_type        item_ff, item_in;
   logic                in_vld_ff, in_vld_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic [DUTY_W-1:0]   rsp_duty_ff, rsp_duty_in;
   logic [DUTY_W-1:0]   duty_next;
   logic                advance, fire, req_xfer;

   mdt_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   mdt_track u_track (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (item_ff),
      .cfg       (cfg),
      .duty_next (duty_next)
   );

   assign advance        = !rsp_vld_ff || rsp_chan.ready;
   assign fire           = in_vld_ff && advance;
   assign req_chan.ready = !in_vld_ff || advance;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   always_comb begin
      item_in.action     = req_chan.action;
      item_in.voltage    = req_chan.voltage;
      item_in.current    = req_chan.current;
      item_in.power      = req_chan.power;
      item_in.duty_value = req_chan.duty_value;

      in_vld_in = in_vld_ff;
      if (req_xfer) begin
         in_vld_in = 1'b1;
      end else if (fire) begin
         in_vld_in = 1'b0;
      end

      rsp_vld_in  = advance ? in_vld_ff : rsp_vld_ff;
      rsp_duty_in = fire ? duty_next : rsp_duty_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      if (req_xfer) begin
         item_ff <= item_in;
      end
      rsp_duty_ff <= rsp_duty_in;
   end

   assign rsp_chan.valid = rsp_vld_ff;
   assign rsp_chan.duty  = rsp_duty_ff;

   // a full input stage behind a stalled response blocks new requests
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && rsp_vld_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("request accepted while both stages are stalled");

   // a direct load never exceeds the requested value
   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      fire && item_ff.action |=> rsp_duty_ff <= $past(item_ff.duty_value))
      else $error("loaded duty above requested value");

   // a tracking sample in stopped mode drives the duty to zero
   a_stop_zero: assert property (@(posedge clock) disable iff (reset)
      fire && !item_ff.action && cfg.mode == MODE_STOP |=> rsp_duty_ff == '0)
      else $error("duty not zero in stopped mode");

   // every step moves a result into the response register
   a_fire_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_vld_ff)
      else $error("stepped item produced no response");

endmodule

`default_nettype wire

// ===== verif/mppt_duty_tracker_core_tb.sv =====
// Self-checking testbench for mppt_duty_tracker_core: a directed table, then random
// tracking phases, checked against an in-bench duty predictor or literal expected duties.
// Depends on mdt_pkg, the mdt_*_if interfaces and the core RTL.
`timescale 1ns / 100ps

module mppt_duty_tracker_core_tb;
   import mdt_pkg::*;

   localparam logic                 ACT_SAMPLE     = 1'b0;
   localparam logic                 ACT_LOAD       = 1'b1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 2'd3;
   localparam int                   CYCLE_LIMIT    = 200000;
   localparam int                   PHASES         = 15;
   localparam int                   PHASE_ITEMS    = 50;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] csr_index;
      logic [CSR_DATA_W-1:0] csr_data;
      req_item_type         item;
      bit                   literal;
      logic [DUTY_W-1:0]    duty;
   } stim_row_type;

   logic clock;
   logic reset;

   mdt_req_if req_if ();
   mdt_rsp_if rsp_if ();
   mdt_csr_if csr_if ();

   mppt_duty_tracker_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // tracker shadow: settings and state
   mode_type            trk_mode;
   logic [STEP_W-1:0]   trk_step;
   logic [DUTY_W-1:0]   trk_max;
   logic [POWER_W-1:0]  held_power;
   logic [VOLT_W-1:0]   held_voltage;
   logic [CURR_W-1:0]   held_current;
   logic [DUTY_W-1:0]   duty_now;

   logic [DUTY_W-1:0]   pending_duty[$];
   stim_row_type        stim_rows[$];
   int                  mismatch_count = 0;
   int                  cycle_count = 0;
   bit                  no_stall = 1'b0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic void nudge_duty(int dir);
      logic [DUTY_W:0] d;
      d = {1'b0, duty_now};
      if (dir > 0)
         d = d + trk_step;
      else if (dir < 0)
         d = (duty_now > trk_step) ? d - trk_step : '0;
      else
         return;
      if (d > trk_max)
         d = {1'b0, trk_max};
      duty_now = d[DUTY_W-1:0];
   endfunction

   function automatic int sign_of(longint x);
      return (x > 0) ? 1 : ((x < 0) ? -1 : 0);
   endfunction

   function automatic logic [DUTY_W-1:0] track_item(req_item_type it);
      longint dv;
      longint di;
      longint num;
      bit     vup;
      if (it.action == ACT_LOAD) begin
         duty_now = (it.duty_value > trk_max) ? trk_max : it.duty_value;
      end else begin
         case (trk_mode)
            MODE_STOP: begin
               duty_now = '0;
            end
            MODE_PNO: begin
               vup = it.voltage > held_voltage;
               if (it.power > held_power)
                  nudge_duty(vup ? 1 : -1);
               else if (it.power < held_power)
                  nudge_duty(vup ? -1 : 1);
               held_power   = it.power;
               held_voltage = it.voltage;
               held_current = it.current;
            end
            MODE_INC_COND: begin
               dv = longint'(it.voltage) - longint'(held_voltage);
               di = longint'(it.current) - longint'(held_current);
               if (dv != 0) begin
                  num = di * longint'(it.voltage) + longint'(it.current) * dv;
                  nudge_duty(sign_of(num) * sign_of(dv));
               end
               held_voltage = it.voltage;
               held_current = it.current;
            end
            default: ;
         endcase
      end
      return duty_now;
   endfunction

   function automatic void store_setting(logic [CSR_IDX_W-1:0] idx,
                                         logic [CSR_DATA_W-1:0] data);
      if (idx == CSR_MODE)
         trk_mode = mode_type'(data[1:0]);
      else if (idx == CSR_DUTY_STEP)
         trk_step = data[STEP_W-1:0];
      else if (idx == CSR_DUTY_MAX)
         trk_max = data[DUTY_W-1:0];
   endfunction

   function automatic void add_item(logic act, logic [VOLT_W-1:0] v, logic [CURR_W-1:0] i,
                                    logic [POWER_W-1:0] p, logic [DUTY_W-1:0] dval,
                                    bit lit, logic [DUTY_W-1:0] lit_duty);
      stim_row_type r;
      r.kind            = ROW_ITEM;
      r.csr_index       = '0;
      r.csr_data        = '0;
      r.item.action     = act;
      r.item.voltage    = v;
      r.item.current    = i;
      r.item.power      = p;
      r.item.duty_value = dval;
      r.literal         = lit;
      r.duty            = lit_duty;
      stim_rows.push_back(r);
   endfunction

   function automatic void add_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      stim_row_type r;
      r.kind      = ROW_CSR;
      r.csr_index = idx;
      r.csr_data  = data;
      r.item      = '0;
      r.literal   = 1'b0;
      r.duty      = '0;
      stim_rows.push_back(r);
   endfunction

   task automatic send_item(input req_item_type it, input bit lit,
                            input logic [DUTY_W-1:0] lit_duty);
      int                gap;
      logic [DUTY_W-1:0] predicted;
      gap = no_stall ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid      <= 1'b1;
      req_if.action     <= it.action;
      req_if.voltage    <= it.voltage;
      req_if.current    <= it.current;
      req_if.power      <= it.power;
      req_if.duty_value <= it.duty_value;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predicted = track_item(it);
      pending_duty.push_back(lit ? lit_duty : predicted);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      store_setting(idx, data);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // drop valid, wait for every pending duty, then let the pipeline settle
   task automatic drain;
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_duty.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // response side: hold ready low for a random stretch, then wait for one transfer
   initial begin
      int gap;
      rsp_if.ready = 1'b0;
      forever begin
         gap = no_stall ? 0 : $urandom_range(0, 7);
         if (gap != 0) begin
            @(negedge clock);
            rsp_if.ready <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
      end
   end

   always @(posedge clock) begin
      logic [DUTY_W-1:0] want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_duty.size() == 0) begin
            $error("duty: expected none, actual %h", rsp_if.duty);
            mismatch_count++;
         end else begin
            want = pending_duty.pop_front();
            if (rsp_if.duty !== want) begin
               $error("duty: expected %h, actual %h", want, rsp_if.duty);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      req_item_type       it;
      logic [VOLT_W-1:0]  gen_v;
      logic [CURR_W-1:0]  gen_i;
      logic [POWER_W-1:0] gen_p;
      logic [DUTY_W-1:0]  max_val;
      logic [STEP_W-1:0]  step_val;
      mode_type           mode_val;
      int                 pick;

      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.action     = ACT_SAMPLE;
      req_if.voltage    = '0;
      req_if.current    = '0;
      req_if.power      = '0;
      req_if.duty_value = '0;
      csr_if.valid      = 1'b0;
      csr_if.index      = CSR_MODE;
      csr_if.data       = '0;

      trk_mode     = MODE_STOP;
      trk_step     = DUTY_STEP_RESET;
      trk_max      = DUTY_MAX_RESET;
      held_power   = '0;
      held_voltage = '0;
      held_current = '0;
      duty_now     = '0;

      // stopped after reset, loads, power rise/fall/equal in both directions
      add_item(ACT_SAMPLE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hA5A5, 1, 16'h0000);
      add_item(ACT_LOAD,   16'h0000, 16'h0000, 32'h0000_0000, 16'hFFFF, 1, 16'hFFFF);
      add_item(ACT_SAMPLE, 16'h0000, 16'h0000, 32'h0000_0000, 16'h5A5A, 1, 16'h0000);
      add_csr(CSR_MODE, {14'h0000, MODE_PNO});
      add_item(ACT_LOAD,   16'h0000, 16'h0000, 32'h0000_0000, 16'd100, 1, 16'd100);
      add_item(ACT_SAMPLE, 16'd10, 16'd5, 32'd50, 16'h0000, 0, '0);
      add_item(ACT_SAMPLE, 16'd20, 16'd4, 32'd40, 16'h0000, 0, '0);
      add_item(ACT_SAMPLE, 16'd15, 16'd4, 32'd60, 16'h0000, 0, '0);
      add_item(ACT_SAMPLE, 16'd10, 16'd3, 32'd30, 16'h0000, 0, '0);
      add_item(ACT_SAMPLE, 16'd10, 16'd3, 32'd30, 16'h0000, 0, '0);
      // upper data bits beyond the step width must be dropped
      add_csr(CSR_DUTY_STEP, 16'hFFFF);
      add_item(ACT_LOAD,   16'h0000, 16'h0000, 32'h0000_0000, 16'h0000, 1, 16'h0000);
      add_item(ACT_SAMPLE, 16'd5, 16'd100, 32'd500, 16'h0000, 0, '0);
      add_csr(CSR_DUTY_MAX, 16'h0100);
      add_item(ACT_LOAD,   16'h0000, 16'h0000, 32'h0000_0000, 16'hFFFF, 1, 16'h0100);
      add_item(ACT_SAMPLE, 16'd6, 16'd100, 32'd600, 16'h0000, 0, '0);
      add_csr(CSR_MODE, {14'h0000, MODE_INC_COND});
      add_item(ACT_SAMPLE, 16'd6, 16'd50, 32'd300, 16'h0000, 0, '0);
      add_item(ACT_SAMPLE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'h0000, 0, '0);
      add_item(ACT_SAMPLE, 16'h0000, 16'h0000, 32'h0000_0000, 16'h0000, 0, '0);
      add_csr(CSR_UNUSED_IDX, 16'hFFFF);
      add_csr(CSR_MODE, {14'h0000, MODE_HOLD});
      add_item(ACT_SAMPLE, 16'd1234, 16'd567, 32'h0000_89AB, 16'h0000, 0, '0);
      // duty above a lowered limit stays until a step or load
      add_csr(CSR_DUTY_MAX, 16'h0000);
      add_item(ACT_SAMPLE, 16'h8000, 16'h8000, 32'h8000_0000, 16'h0000, 0, '0);
      add_item(ACT_LOAD,   16'h0000, 16'h0000, 32'h0000_0000, 16'h00FF, 1, 16'h0000);
      add_csr(CSR_MODE, {14'h0000, MODE_STOP});
      add_item(ACT_SAMPLE, 16'h1111, 16'h2222, 32'h3333_4444, 16'h0000, 1, 16'h0000);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[k]) begin
         if (stim_rows[k].kind == ROW_CSR) begin
            drain();
            write_reg(stim_rows[k].csr_index, stim_rows[k].csr_data);
         end else begin
            send_item(stim_rows[k].item, stim_rows[k].literal, stim_rows[k].duty);
         end
      end

      gen_v = $urandom_range(0, 65535);
      gen_i = $urandom_range(0, 65535);
      gen_p = $urandom();
      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         mode_val = (ph < 8) ? mode_type'(ph % 4) : mode_type'($urandom_range(0, 3));
         pick = $urandom_range(0, 5);
         step_val = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 :
                    (pick == 2) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 16));
         pick = $urandom_range(0, 5);
         max_val = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF :
                   (pick == 2) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(200, 5000));
         write_reg(CSR_MODE, {14'($urandom_range(0, 16383)), mode_val});
         write_reg(CSR_DUTY_STEP, {8'($urandom_range(0, 255)), step_val});
         write_reg(CSR_DUTY_MAX, max_val);
         if ($urandom_range(0, 3) == 0)
            write_reg(CSR_UNUSED_IDX, 16'($urandom_range(0, 65535)));
         no_stall = ($urandom_range(0, 4) == 0);

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 15);
            it.duty_value = 16'($urandom_range(0, 65535));
            it.voltage    = gen_v;
            it.current    = gen_i;
            it.power      = gen_p;
            if (pick == 0) begin
               it.action = ACT_LOAD;
               case ($urandom_range(0, 3))
                  0: it.duty_value = 16'h0000;
                  1: it.duty_value = 16'hFFFF;
                  2: it.duty_value = max_val;
                  default: ;
               endcase
            end else if (pick <= 2) begin
               // noise: unrelated samples
               it.action  = ACT_SAMPLE;
               it.voltage = 16'($urandom_range(0, 65535));
               it.current = 16'($urandom_range(0, 65535));
               it.power   = $urandom();
            end else begin
               // walk the operating point in small steps
               it.action  = ACT_SAMPLE;
               it.voltage = gen_v + 16'(int'($urandom_range(0, 12)) - 6);
               it.current = gen_i + 16'(int'($urandom_range(0, 12)) - 6);
               case ($urandom_range(0, 3))
                  0: it.power = gen_p;
                  1: it.power = gen_p + 32'(int'($urandom_range(0, 64)) - 32);
                  default: it.power = 32'(it.voltage) * 32'(it.current);
               endcase
            end
            if (it.action == ACT_SAMPLE) begin
               gen_v = it.voltage;
               gen_i = it.current;
               gen_p = it.power;
            end
            send_item(it, 1'b0, '0);
         end
      end

      drain();
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
